>>> rtl/terrain_lod_strip_index_generator_assert.svh
// assertion macros shared by the checker of the strip index generator
`ifndef TERRAIN_LOD_STRIP_INDEX_GENERATOR_ASSERT_SVH
`define TERRAIN_LOD_STRIP_INDEX_GENERATOR_ASSERT_SVH

// same-cycle implication, clocked on i_clk, quiet while i_rst_n is low
`define TLSIG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, quiet while i_rst_n is low
`define TLSIG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tlsig_pkg.sv
// shared constants and types of the terrain strip index generator
`default_nettype none

package tlsig_pkg;

    localparam int VERTS_PER_SIDE = 33;
    localparam int MAX_LEVELS     = 6;
    localparam int NUM_PIECES     = 5;

    localparam int LVL_W  = 3;
    localparam int CNT_W  = 9;
    localparam int IDX_W  = 16;
    localparam int SIDE_W = $clog2(VERTS_PER_SIDE);

    // piece codes, in strip order
    localparam logic [2:0] PIECE_BODY  = 3'd0;
    localparam logic [2:0] PIECE_NORTH = 3'd1;
    localparam logic [2:0] PIECE_SOUTH = 3'd2;
    localparam logic [2:0] PIECE_WEST  = 3'd3;
    localparam logic [2:0] PIECE_EAST  = 3'd4;

    // patch, north, south, west, east from element 0 up
    typedef logic [NUM_PIECES-1:0][LVL_W-1:0] t_levels;

    typedef struct packed {
        logic                  nc;        // patch is not the coarsest level
        logic [SIDE_W-1:0]     side;      // tiles along a side at the patch level
        logic                  body_pos;  // inset body keeps at least one tile
        logic [SIDE_W-1:0]     body_t;    // body tiles, meaningful when body_pos
        logic [NUM_PIECES-1:0] present;
    } t_geom;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic             last;
        logic             valid_res;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/tlsig_index.sv
// vertex index of one strip element from piece, column, row and pair half
`default_nettype none

module tlsig_index (
    input  tlsig_pkg::t_geom                i_geom,
    input  tlsig_pkg::t_levels              i_levels,
    input  logic [2:0]                      i_piece,
    input  logic [tlsig_pkg::CNT_W-1:0]     i_col,
    input  logic [tlsig_pkg::CNT_W-1:0]     i_row,
    input  logic                            i_second,
    output logic [tlsig_pkg::IDX_W-1:0]     o_index
);
    import tlsig_pkg::*;

    localparam logic [IDX_W-1:0] V_IDX = IDX_W'(VERTS_PER_SIDE);
    localparam logic [IDX_W-1:0] VM1   = IDX_W'(VERTS_PER_SIDE - 1);
    localparam logic [IDX_W-1:0] VM1V  = IDX_W'((VERTS_PER_SIDE - 1) * VERTS_PER_SIDE);
    localparam logic [IDX_W-1:0] VVM1  = IDX_W'(VERTS_PER_SIDE * VERTS_PER_SIDE - 1);

    // constant multiply by the grid pitch, wrapping at the index width
    function automatic logic [IDX_W-1:0] mulv(input logic [IDX_W-1:0] a);
        return IDX_W'(a * V_IDX);
    endfunction

    logic [LVL_W-1:0] h0;
    logic [LVL_W-1:0] hp;
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] rs;
    logic [IDX_W-1:0] xs;
    logic [IDX_W-1:0] yrs;
    logic [IDX_W-1:0] start;
    logic [IDX_W-1:0] tts;
    logic [IDX_W-1:0] nmask;
    logic [IDX_W-1:0] f;
    logic [CNT_W-1:0] lastc;

    always_comb begin
        h0 = i_levels[0];
        case (i_piece)
            PIECE_NORTH: hp = i_levels[1];
            PIECE_SOUTH: hp = i_levels[2];
            PIECE_WEST:  hp = i_levels[3];
            PIECE_EAST:  hp = i_levels[4];
            default:     hp = '0;
        endcase

        s     = IDX_W'(1) << h0;
        rs    = mulv(s);
        xs    = IDX_W'(i_col) << h0;
        yrs   = mulv(IDX_W'(i_row)) << h0;
        start = i_geom.nc ? (rs + s) : '0;
        tts   = IDX_W'(i_geom.body_t) << h0;
        nmask = ~((IDX_W'(1) << hp) - IDX_W'(1));
        f     = xs & nmask;
        lastc = (i_geom.side == '0) ? CNT_W'(1) : CNT_W'(i_geom.side);

        o_index = '0;
        if (i_piece == PIECE_BODY) begin
            if (i_col <= CNT_W'(i_geom.body_t)) begin
                o_index = i_second ? (start + yrs + xs) : (start + yrs + rs + xs);
            end else begin
                // row end: repeat, then first index of the next row
                o_index = i_second ? (start + yrs + rs + rs) : (start + yrs + tts);
            end
        end else if (i_col == '0) begin
            case (i_piece)
                PIECE_SOUTH: o_index = VM1V;
                PIECE_EAST:  o_index = VM1;
                default:     o_index = '0;
            endcase
        end else if (i_col >= lastc) begin
            case (i_piece)
                PIECE_NORTH: o_index = VM1;
                PIECE_WEST:  o_index = VM1V;
                default:     o_index = VVM1;
            endcase
        end else begin
            case (i_piece)
                PIECE_NORTH: o_index = i_second ? f : (rs + xs);
                PIECE_SOUTH: o_index = i_second ? (mulv(VM1 - s) + xs) : (VM1V + f);
                PIECE_WEST:  o_index = i_second ? (mulv(xs) + s) : mulv(f);
                PIECE_EAST:  o_index = i_second ? (mulv(f) + VM1) : (mulv(xs) + (VM1 - s));
                default:     o_index = '0;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/tlsig_walker.sv
// strip walk state: latched levels, piece, counters, pair phase, one word per item
`default_nettype none

module tlsig_walker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_start,
    input  tlsig_pkg::t_levels            i_levels,
    input  logic                          i_cfg_wr,
    input  logic [tlsig_pkg::LVL_W-1:0]   i_level_count,
    output tlsig_pkg::t_result            o_result
);
    import tlsig_pkg::*;

    typedef enum logic [3:0] {
        PH_PAIR_A     = 4'b0001,
        PH_PAIR_B     = 4'b0010,
        PH_JOIN_REP   = 4'b0100,
        PH_JOIN_FIRST = 4'b1000
    } t_phase;

    function automatic t_geom geom_of(input t_levels lv, input logic [LVL_W-1:0] lc);
        logic [LVL_W+1:0] c;
        logic             key_ok;
        logic             base_ok;
        logic [SIDE_W+1:0] bt;
        t_geom            g;
        c = ({2'b00, lc} > (LVL_W+2)'(MAX_LEVELS)) ? (LVL_W+2)'(MAX_LEVELS) : {2'b00, lc};
        key_ok = 1'b1;
        for (int i = 0; i < NUM_PIECES; i++) begin
            if ({2'b00, lv[i]} >= (LVL_W+2)'(MAX_LEVELS)) begin
                key_ok = 1'b0;
            end
        end
        g.nc       = ({2'b00, lv[0]} + (LVL_W+2)'(1)) < c;
        g.side     = SIDE_W'((VERTS_PER_SIDE - 1) >> lv[0]);
        bt         = {2'b00, g.side} - (g.nc ? (SIDE_W+2)'(2) : '0);
        g.body_pos = !bt[SIDE_W+1] && (bt != '0);
        g.body_t   = bt[SIDE_W-1:0];
        base_ok    = key_ok && ({2'b00, lv[0]} < c);
        g.present[0] = base_ok && g.body_pos;
        for (int p = 1; p < NUM_PIECES; p++) begin
            g.present[p] = base_ok && g.nc && ({2'b00, lv[p]} < c) && (lv[p] >= lv[0]);
        end
        return g;
    endfunction

    t_levels          r_levels, n_levels;
    logic [2:0]       r_piece, n_piece;
    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    t_phase           r_phase, n_phase;
    logic [IDX_W-1:0] r_prev, n_prev;
    logic             r_active, n_active;

    t_levels          lv_eff;
    t_geom            geom;
    logic [2:0]       first_piece;
    logic [2:0]       nxt_piece;
    logic             nxt_found;
    logic [2:0]       piece_eff;
    logic [CNT_W-1:0] col_eff;
    logic [CNT_W-1:0] row_eff;
    t_phase           phase_eff;
    logic             act_eff;
    logic [CNT_W-1:0] elem_col;
    logic [CNT_W-1:0] elem_row;
    logic             elem_second;
    logic [IDX_W-1:0] elem_idx;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cols;
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] col_inc;
    logic [CNT_W-1:0] row_inc;
    logic             fin;

    always_comb begin
        lv_eff = i_start ? i_levels : r_levels;
        geom   = geom_of(lv_eff, i_level_count);

        first_piece = PIECE_BODY;
        for (int p = NUM_PIECES - 1; p >= 0; p--) begin
            if (geom.present[p]) begin
                first_piece = 3'(p);
            end
        end

        piece_eff = i_start ? first_piece : r_piece;
        col_eff   = i_start ? '0 : r_col;
        row_eff   = i_start ? '0 : r_row;
        phase_eff = i_start ? PH_PAIR_A : r_phase;
        act_eff   = i_start ? (|geom.present) : r_active;

        nxt_piece = PIECE_BODY;
        nxt_found = 1'b0;
        for (int p = NUM_PIECES - 1; p >= 0; p--) begin
            if (geom.present[p] && (3'(p) > piece_eff)) begin
                nxt_piece = 3'(p);
                nxt_found = 1'b1;
            end
        end

        // join first index is element (0, 0) of the new piece
        elem_col    = (phase_eff == PH_JOIN_FIRST) ? '0 : col_eff;
        elem_row    = (phase_eff == PH_JOIN_FIRST) ? '0 : row_eff;
        elem_second = (phase_eff == PH_PAIR_B);
    end

    tlsig_index u_index (
        .i_geom   (geom),
        .i_levels (lv_eff),
        .i_piece  (piece_eff),
        .i_col    (elem_col),
        .i_row    (elem_row),
        .i_second (elem_second),
        .o_index  (elem_idx)
    );

    always_comb begin
        idx = (phase_eff == PH_JOIN_REP) ? r_prev : elem_idx;

        if (piece_eff == PIECE_BODY) begin
            cols = geom.body_pos ? (CNT_W'(geom.body_t) + CNT_W'(1)) : CNT_W'(1);
            rows = geom.body_pos ? (CNT_W'(geom.body_t) - CNT_W'(1)) : '0;
        end else begin
            cols = (geom.side == '0) ? CNT_W'(1) : CNT_W'(geom.side);
            rows = '0;
        end
        col_inc = col_eff + CNT_W'(1);
        row_inc = row_eff + CNT_W'(1);

        n_levels = lv_eff;
        n_piece  = piece_eff;
        n_col    = col_eff;
        n_row    = row_eff;
        n_phase  = phase_eff;
        n_active = act_eff;
        n_prev   = r_prev;
        fin      = 1'b0;

        if (act_eff) begin
            n_prev = idx;
            case (phase_eff)
                PH_JOIN_REP: begin
                    n_phase = PH_JOIN_FIRST;
                end
                PH_JOIN_FIRST: begin
                    n_phase = PH_PAIR_A;
                    n_col   = '0;
                    n_row   = '0;
                end
                PH_PAIR_A: begin
                    n_phase = PH_PAIR_B;
                end
                PH_PAIR_B: begin
                    n_phase = PH_PAIR_A;
                    if (col_inc <= cols) begin
                        n_col = col_inc;
                    end else if (row_inc <= rows) begin
                        n_col = '0;
                        n_row = row_inc;
                    end else begin
                        n_col = '0;
                        n_row = '0;
                        if (nxt_found) begin
                            n_piece = nxt_piece;
                            n_phase = PH_JOIN_REP;
                        end else begin
                            n_active = 1'b0;
                            fin      = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_PAIR_A;
                end
            endcase
        end

        o_result.vertex_index = act_eff ? idx : '0;
        o_result.last         = fin;
        o_result.valid_res    = act_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= '0;
            r_piece  <= PIECE_BODY;
            r_col    <= '0;
            r_row    <= '0;
            r_phase  <= PH_PAIR_A;
            r_prev   <= '0;
            r_active <= 1'b0;
        end else if (i_cfg_wr) begin
            r_active <= 1'b0;
        end else if (i_accept) begin
            r_levels <= n_levels;
            r_piece  <= n_piece;
            r_col    <= n_col;
            r_row    <= n_row;
            r_phase  <= n_phase;
            r_prev   <= n_prev;
            r_active <= n_active;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tlsig_obuf.sv
// two-entry output register with skid stage
`default_nettype none

module tlsig_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tlsig_pkg::t_result  i_data,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output tlsig_pkg::t_result  o_data
);
    import tlsig_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    main_free;

    assign o_ready   = !r_skid_valid;
    assign o_valid   = r_main_valid;
    assign o_data    = r_main;
    assign main_free = !r_main_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (main_free) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (main_free) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/terrain_lod_strip_index_generator.sv
// top level of the terrain patch triangle-strip index generator
//
//  channel   | dir | handshake        | contents
//  ----------+-----+------------------+------------------------------------------
//  s_axis    | in  | tvalid / tready  | tuser: mode, tdata: five detail levels
//  m_axis    | out | tvalid / tready  | tdata: vertex index, tlast, tuser: valid
//  apb       | in  | psel / penable   | register 0 at byte 0: level_count
//
//  one word in, one word out; a word can be taken on every clock while s_axis_tready
//  is high, and its result is registered in the output buffer
//  index, piece and phase logic sit between the walk state and the output register
//  a two-deep output buffer keeps s_axis_tready high until its skid stage holds a word
//  i_rst_n is synchronous, active low; level_count returns to 6, strip idle
//  a level_count write abandons any strip still running
`default_nettype none

module terrain_lod_strip_index_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [2:0] patch_level, [5:3] north_level,
                                        // [8:6] south_level, [11:9] west_level,
                                        // [14:12] east_level, [15] zero
    input  logic        s_axis_tuser,   // [0] mode
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] vertex_index
    output logic        m_axis_tlast,   // last
    output logic        m_axis_tuser,   // [0] valid_res
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tlsig_pkg::*;

    localparam logic       MODE_START          = 1'b0;
    localparam logic       REG_IDX_LEVEL_COUNT = 1'b0;
    localparam logic [LVL_W-1:0] LEVEL_COUNT_RST = LVL_W'(6);

    logic [LVL_W-1:0] r_level_count;
    logic             cfg_wr;
    logic             lc_wr;
    logic             in_accept;
    logic             buf_ready;
    t_levels          in_levels;
    t_result          step_result;
    t_result          out_word;

    // register port: zero wait states, word index in paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign lc_wr  = cfg_wr && (paddr[2] == REG_IDX_LEVEL_COUNT);
    assign prdata = (paddr[2] == REG_IDX_LEVEL_COUNT) ?
                    {{(32-LVL_W){1'b0}}, r_level_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count <= LEVEL_COUNT_RST;
        end else if (lc_wr) begin
            r_level_count <= pwdata[LVL_W-1:0];
        end
    end

    // input word: levels packed from patch up, bit 15 is fill
    assign in_levels     = s_axis_tdata[NUM_PIECES*LVL_W-1:0];
    assign s_axis_tready = buf_ready;
    assign in_accept     = s_axis_tvalid && buf_ready;

    tlsig_walker u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_start       (s_axis_tuser == MODE_START),
        .i_levels      (in_levels),
        .i_cfg_wr      (lc_wr),
        .i_level_count (r_level_count),
        .o_result      (step_result)
    );

    // every accepted word yields exactly one output word
    tlsig_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (step_result),
        .o_ready (buf_ready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_word)
    );

    assign m_axis_tdata = out_word.vertex_index;
    assign m_axis_tlast = out_word.last;
    assign m_axis_tuser = out_word.valid_res;

endmodule

`default_nettype wire

>>> rtl/tlsig_checker.sv
// port-level checker for the strip index generator, bound to the top level
`default_nettype none
`include "terrain_lod_strip_index_generator_assert.svh"

module tlsig_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser,
    input logic        pready
);

    // a stalled output word stays offered
    `TLSIG_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word dropped while stalled")

    // the final index of a strip is always a real index
    `TLSIG_ASSERT_IMP(a_last_is_valid, m_axis_tvalid && m_axis_tlast, m_axis_tuser, "tlast without valid index")

    // an idle or empty word carries all-zero fields
    `TLSIG_ASSERT_IMP(a_empty_zero, m_axis_tvalid && !m_axis_tuser, (m_axis_tdata == 16'd0) && !m_axis_tlast, "empty word not zero")

    // input backpressure only with a result waiting at the output
    `TLSIG_ASSERT_IMP(a_ready_low_full, !s_axis_tready, m_axis_tvalid && pready, "input stalled with output empty")

    // after each accepted word, the output holds a valid word on the next cycle
    `TLSIG_ASSERT_NXT(a_accept_out, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "accepted word produced no output")

endmodule

bind terrain_lod_strip_index_generator tlsig_checker u_tlsig_checker (.*);

`default_nettype wire
